/* hw/rtl/hsh_pkg.sv */
// Shared types, constants and helpers of the HMAC-SHA1 engine.
package hsh_pkg;

  localparam logic [7:0] IPAD_BYTE    = 8'h36;
  localparam logic [7:0] OPAD_BYTE    = 8'h5c;
  localparam int         BLOCK_BYTES  = 64;
  localparam int         DIGEST_BYTES = 20;

  localparam logic [31:0] SHA_IV0 = 32'h67452301;
  localparam logic [31:0] SHA_IV1 = 32'hEFCDAB89;
  localparam logic [31:0] SHA_IV2 = 32'h98BADCFE;
  localparam logic [31:0] SHA_IV3 = 32'h10325476;
  localparam logic [31:0] SHA_IV4 = 32'hC3D2E1F0;

  typedef struct packed {
    logic       start;
    logic       finish;
    logic       byte_v;
    logic [7:0] data;
  } sha_cmd_t;

  typedef enum logic [2:0] {
    SH_IDLE, SH_COMP, SH_P80, SH_PZ, SH_PLEN
  } sha_state_t;

  typedef enum logic [3:0] {
    T_KEY, T_START, T_RD, T_FEED, T_XTRA, T_KFIN, T_KFW, T_KWR,
    T_MSG, T_IFIN, T_IFW, T_DIG, T_OFIN, T_OFW, T_OUT
  } top_state_t;

  typedef enum logic [1:0] {
    M_KHASH, M_IPAD, M_OPAD
  } feed_mode_t;

  // Byte idx of a 160-bit digest, big-endian order
  function automatic logic [7:0] digest_byte(input logic [159:0] dg, input logic [4:0] idx);
    logic [159:0] sh;
    sh = dg << {idx, 3'b000};
    return sh[159:152];
  endfunction

endpackage

/* hw/rtl/hsh_sha.sv */
// SHA-1 core: byte absorber, padding sequencer and one-round-per-cycle compressor.
module hsh_sha (
  input  logic              clk,
  input  logic              rst_n,
  input  hsh_pkg::sha_cmd_t cmd,
  output logic              rdy,
  output logic [159:0]      digest
);
  import hsh_pkg::*;

  sha_state_t  state_r, state_nxt, ret_r, ret_nxt, after;
  logic [31:0] h_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [511:0] blk_r;
  logic [63:0] cnt_r, cnt_inc, bits_r;
  logic [6:0]  rnd_r;
  logic [2:0]  len_idx_r;
  logic        abs_v, wrap;
  logic [7:0]  abs_b;
  logic [31:0] f, k, wt, wnew, t;

  assign rdy     = (state_r == SH_IDLE);
  assign digest  = {h_r[0], h_r[1], h_r[2], h_r[3], h_r[4]};
  assign cnt_inc = cnt_r + 64'd1;
  assign wrap    = abs_v && (cnt_inc[5:0] == 6'd0);

  // absorb source
  always_comb begin
    abs_v = 1'b0;
    abs_b = 8'h00;
    unique case (state_r)
      SH_IDLE: begin
        abs_v = cmd.byte_v;
        abs_b = cmd.data;
      end
      SH_P80: begin
        abs_v = 1'b1;
        abs_b = 8'h80;
      end
      SH_PZ: begin
        abs_v = 1'b1;
      end
      SH_PLEN: begin
        abs_v = 1'b1;
        abs_b = bits_r[63:56];
      end
      default: begin
        abs_v = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    after = state_r;
    unique case (state_r)
      SH_IDLE: after = cmd.finish ? SH_P80 : SH_IDLE;
      SH_P80, SH_PZ: after = (cnt_inc[5:0] == 6'd56) ? SH_PLEN : SH_PZ;
      SH_PLEN: after = (len_idx_r == 3'd7) ? SH_IDLE : SH_PLEN;
      SH_COMP: after = (rnd_r == 7'd79) ? ret_r : SH_COMP;
      default: after = SH_IDLE;
    endcase
    state_nxt = wrap ? SH_COMP : after;
    ret_nxt   = wrap ? after : ret_r;
  end

  // round function
  always_comb begin
    priority if (rnd_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r);
      k = 32'h5A827999;
    end else if (rnd_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r;
      k = 32'h6ED9EBA1;
    end else if (rnd_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k = 32'h8F1BBCDC;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = 32'hCA62C1D6;
    end
    wt   = blk_r[511:480];
    wnew = blk_r[95:64] ^ blk_r[255:224] ^ blk_r[447:416] ^ wt;
    wnew = {wnew[30:0], wnew[31]};
    t    = {a_r[26:0], a_r[31:27]} + f + e_r + k + wt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= SH_IDLE;
      ret_r     <= SH_IDLE;
      cnt_r     <= '0;
      rnd_r     <= '0;
      len_idx_r <= '0;
      h_r[0] <= SHA_IV0; h_r[1] <= SHA_IV1; h_r[2] <= SHA_IV2;
      h_r[3] <= SHA_IV3; h_r[4] <= SHA_IV4;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      if (state_r == SH_IDLE && cmd.start) begin
        h_r[0] <= SHA_IV0; h_r[1] <= SHA_IV1; h_r[2] <= SHA_IV2;
        h_r[3] <= SHA_IV3; h_r[4] <= SHA_IV4;
        cnt_r  <= '0;
      end
      if (abs_v) begin
        blk_r <= {blk_r[503:0], abs_b};
        cnt_r <= cnt_inc;
      end
      if (state_r == SH_IDLE && cmd.finish) begin
        bits_r    <= {cnt_r[60:0], 3'b000};
        len_idx_r <= '0;
      end
      if (state_r == SH_PLEN) begin
        bits_r    <= {bits_r[55:0], 8'h00};
        len_idx_r <= len_idx_r + 3'd1;
      end
      if (wrap) begin
        a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
        rnd_r <= '0;
      end
      if (state_r == SH_COMP) begin
        blk_r <= {blk_r[479:0], wnew};
        a_r <= t;
        b_r <= a_r;
        c_r <= {b_r[1:0], b_r[31:2]};
        d_r <= c_r;
        e_r <= d_r;
        rnd_r <= rnd_r + 7'd1;
        if (rnd_r == 7'd79) begin
          h_r[0] <= h_r[0] + t;
          h_r[1] <= h_r[1] + a_r;
          h_r[2] <= h_r[2] + {b_r[1:0], b_r[31:2]};
          h_r[3] <= h_r[3] + c_r;
          h_r[4] <= h_r[4] + d_r;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == SH_COMP |-> rnd_r < 7'd80) else $error("round counter overrun");
  a_start_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (rdy && cmd.start && !cmd.byte_v) |=> cnt_r == 64'd0) else $error("start left count");
  a_len_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == SH_PLEN |-> cnt_r[5:3] == 3'd7) else $error("length bytes misplaced");
`endif

endmodule

/* hw/rtl/hmac_sha1_engine.sv */
// HMAC-SHA1 engine top level: key store memory and HMAC sequencer.
// Key bytes up to 64 are stored in key memory; beyond that, key and message bytes are
// absorbed by SHA-1, with input held off while each 64-byte block is compressed.
// Key end: the inner pad block is fed one byte per key memory read and compressed before
// the first message item; a long key is first finished and its digest written back.
// Message end: padding, outer pad block, 20 digest bytes and up to 4 compressions,
// then five output words, one per cycle while out_tready is high. Rounds set the rate.
// Synchronous active-low reset returns to waiting for a key; no clearing pass.
module hmac_sha1_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [8] byte_valid, zero above
  input  logic        in_tuser,   // [0] func
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic        out_tlast
);
  import hsh_pkg::*;

  top_state_t  state_r, state_nxt;
  feed_mode_t  mode_r;
  logic [7:0]  key_mem [BLOCK_BYTES];
  logic [7:0]  rd_r, wr_data, byte_r, fbyte, pad;
  logic [5:0]  wr_addr;
  logic        we;
  logic [6:0]  klen_r, cnt_r;
  logic        hashed_r, last_pend_r;
  logic [159:0] inner_r, digest;
  logic        sha_rdy, acc, bv;
  sha_cmd_t    cmd;

  assign acc = in_tvalid && in_tready;
  assign bv  = in_tdata[8];
  assign pad = (mode_r == M_IPAD) ? IPAD_BYTE : OPAD_BYTE;
  assign fbyte = (mode_r == M_KHASH) ? rd_r :
                 (((cnt_r < klen_r) ? rd_r : 8'h00) ^ pad);

  hsh_sha u_sha (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .rdy    (sha_rdy),
    .digest (digest)
  );

  always_ff @(posedge clk) begin
    if (we) key_mem[wr_addr] <= wr_data;
    rd_r <= key_mem[cnt_r[5:0]];
  end

  // outputs
  always_comb begin
    in_tready  = sha_rdy && (state_r == T_KEY || state_r == T_MSG);
    cmd        = '0;
    we         = 1'b0;
    wr_addr    = klen_r[5:0];
    wr_data    = in_tdata[7:0];
    out_tvalid = 1'b0;
    out_tdata  = digest[159:128];
    out_tlast  = 1'b0;
    unique case (state_r)
      T_KEY: begin
        if (acc && !in_tuser && bv) begin
          cmd.byte_v = hashed_r;
          cmd.data   = in_tdata[7:0];
          we         = !hashed_r && !klen_r[6];
        end
      end
      T_MSG: begin
        cmd.byte_v = acc && in_tuser && bv;
        cmd.data   = in_tdata[7:0];
      end
      T_START: cmd.start = sha_rdy;
      T_FEED: begin
        cmd.byte_v = sha_rdy;
        cmd.data   = fbyte;
      end
      T_XTRA: begin
        cmd.byte_v = sha_rdy;
        cmd.data   = byte_r;
      end
      T_DIG: begin
        cmd.byte_v = sha_rdy;
        cmd.data   = digest_byte(inner_r, cnt_r[4:0]);
      end
      T_KFIN, T_IFIN, T_OFIN: cmd.finish = sha_rdy;
      T_KWR: begin
        we      = 1'b1;
        wr_addr = cnt_r[5:0];
        wr_data = digest_byte(digest, cnt_r[4:0]);
      end
      T_OUT: begin
        out_tvalid = 1'b1;
        out_tdata  = digest[159 - 32 * cnt_r[2:0] -: 32];
        out_tlast  = (cnt_r[2:0] == 3'd4);
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_KEY: begin
        if (acc && !in_tuser) begin
          priority if (bv && !hashed_r && klen_r[6]) state_nxt = T_START;
          else if (in_tlast) state_nxt = hashed_r ? T_KFIN : T_START;
          else state_nxt = T_KEY;
        end
      end
      T_START: if (sha_rdy) state_nxt = T_RD;
      T_RD:    state_nxt = T_FEED;
      T_FEED: begin
        if (sha_rdy) begin
          if (cnt_r[5:0] == 6'd63) begin
            unique case (mode_r)
              M_KHASH: state_nxt = T_XTRA;
              M_IPAD:  state_nxt = T_MSG;
              default: state_nxt = T_DIG;
            endcase
          end else begin
            state_nxt = T_RD;
          end
        end
      end
      T_XTRA: if (sha_rdy) state_nxt = last_pend_r ? T_KFIN : T_KEY;
      T_KFIN: if (sha_rdy) state_nxt = T_KFW;
      T_KFW:  if (sha_rdy) state_nxt = T_KWR;
      T_KWR:  if (cnt_r[4:0] == 5'(DIGEST_BYTES - 1)) state_nxt = T_START;
      T_MSG:  if (acc && in_tuser && in_tlast) state_nxt = T_IFIN;
      T_IFIN: if (sha_rdy) state_nxt = T_IFW;
      T_IFW:  if (sha_rdy) state_nxt = T_START;
      T_DIG:  if (sha_rdy && cnt_r[4:0] == 5'(DIGEST_BYTES - 1)) state_nxt = T_OFIN;
      T_OFIN: if (sha_rdy) state_nxt = T_OFW;
      T_OFW:  if (sha_rdy) state_nxt = T_OUT;
      T_OUT:  if (out_tready && cnt_r[2:0] == 3'd4) state_nxt = T_KEY;
      default: state_nxt = T_KEY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_KEY;
      mode_r      <= M_IPAD;
      klen_r      <= '0;
      cnt_r       <= '0;
      hashed_r    <= 1'b0;
      last_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        T_KEY: begin
          if (acc && !in_tuser) begin
            if (bv && !hashed_r && !klen_r[6]) klen_r <= klen_r + 7'd1;
            if (bv && !hashed_r && klen_r[6]) begin
              byte_r      <= in_tdata[7:0];
              last_pend_r <= in_tlast;
              mode_r      <= M_KHASH;
            end else if (in_tlast) begin
              mode_r <= M_IPAD;
            end
          end
        end
        T_START: cnt_r <= '0;
        T_FEED: begin
          if (sha_rdy) begin
            if (cnt_r[5:0] == 6'd63) cnt_r <= '0;
            else cnt_r <= cnt_r + 7'd1;
          end
        end
        T_XTRA: if (sha_rdy) hashed_r <= 1'b1;
        T_KFW:  cnt_r <= '0;
        T_KWR: begin
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r[4:0] == 5'(DIGEST_BYTES - 1)) begin
            klen_r <= 7'(DIGEST_BYTES);
            mode_r <= M_IPAD;
          end
        end
        T_IFW: begin
          inner_r <= digest;
          mode_r  <= M_OPAD;
        end
        T_DIG: if (sha_rdy) cnt_r <= cnt_r + 7'd1;
        T_OFW: cnt_r <= '0;
        T_OUT: begin
          if (out_tready) cnt_r <= cnt_r + 7'd1;
          if (out_tready && cnt_r[2:0] == 3'd4) begin
            klen_r   <= '0;
            hashed_r <= 1'b0;
          end
        end
        default: begin
          cnt_r <= cnt_r;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_cmd_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.byte_v || cmd.start || cmd.finish) |-> sha_rdy) else $error("command to busy core");
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> sha_rdy && !in_tready) else $error("output while core busy");
  a_klen: assert property (@(posedge clk) disable iff (!rst_n)
    klen_r <= 7'(BLOCK_BYTES)) else $error("key length overrun");
`endif

endmodule
